### src/bf16_weight_dot_product_defines.svh
// Assertion macros for the bf16 weight dot product block.
`ifndef BF16_WEIGHT_DOT_PRODUCT_DEFINES_SVH
`define BF16_WEIGHT_DOT_PRODUCT_DEFINES_SVH
`ifndef ASSERT_OFF
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### src/bwdp_pkg.sv
// Types, constants and helper functions for the bf16 weight dot product block.
package bwdp_pkg;

    localparam int          WIDEN_SHIFT = 16;
    localparam logic [31:0] CANON_NAN   = 32'h7FC0_0000;
    localparam logic [7:0]  EXP_MAX     = 8'hFF;

    // Classified input transaction, as held in the queue.
    typedef struct packed {
        logic        w_sign;
        logic [7:0]  w_exp;   // effective exponent (1 for subnormal)
        logic [7:0]  w_sig;   // significand with hidden bit
        logic        w_zero;
        logic        w_inf;
        logic        w_nan;
        logic        a_sign;
        logic [7:0]  a_exp;
        logic [23:0] a_sig;
        logic        a_zero;
        logic        a_inf;
        logic        a_nan;
        logic [31:0] bias;
        logic        first;
        logic        last;
    } t_item;

    // Raw product stage.
    typedef struct packed {
        logic               sign;
        logic               nan;
        logic               inf;
        logic               zero;
        logic [31:0]        prod;
        logic signed [10:0] esum;
        logic [31:0]        bias;
        logic               first;
        logic               last;
    } t_mstage;

    // Rounded product stage.
    typedef struct packed {
        logic [31:0] prod_bits;
        logic [31:0] bias;
        logic        first;
        logic        last;
    } t_pstage;

    // Queue status.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // Leading zero count of a 32-bit word, 32 for zero.
    function automatic logic [5:0] lzc32(input logic [31:0] v);
        logic [5:0] n;
        n = 6'd32;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                n = 6'(31 - i);
            end
        end
        return n;
    endfunction

endpackage

### src/bwdp_front.sv
// Front end: unpacks and classifies the operands of each input transaction.
module bwdp_front (
    input  logic [15:0]          i_weight_bf16,
    input  logic [31:0]          i_activation_f32,
    input  logic [31:0]          i_bias_f32,
    input  logic                 i_first_of_row,
    input  logic                 i_last_of_row,
    output bwdp_pkg::t_item      o_item
);
    import bwdp_pkg::*;

    logic [31:0] w_bits;
    logic        w_exp_zero;
    logic        a_exp_zero;

    assign w_bits     = 32'(i_weight_bf16) << WIDEN_SHIFT;
    assign w_exp_zero = (w_bits[30:23] == 8'd0);
    assign a_exp_zero = (i_activation_f32[30:23] == 8'd0);

    always_comb begin
        o_item.w_sign = w_bits[31];
        o_item.w_exp  = w_exp_zero ? 8'd1 : w_bits[30:23];
        o_item.w_sig  = {!w_exp_zero, w_bits[22:16]};
        o_item.w_zero = w_exp_zero && (w_bits[22:16] == 7'd0);
        o_item.w_inf  = (w_bits[30:23] == EXP_MAX) && (w_bits[22:16] == 7'd0);
        o_item.w_nan  = (w_bits[30:23] == EXP_MAX) && (w_bits[22:16] != 7'd0);
        o_item.a_sign = i_activation_f32[31];
        o_item.a_exp  = a_exp_zero ? 8'd1 : i_activation_f32[30:23];
        o_item.a_sig  = {!a_exp_zero, i_activation_f32[22:0]};
        o_item.a_zero = a_exp_zero && (i_activation_f32[22:0] == 23'd0);
        o_item.a_inf  = (i_activation_f32[30:23] == EXP_MAX)
                        && (i_activation_f32[22:0] == 23'd0);
        o_item.a_nan  = (i_activation_f32[30:23] == EXP_MAX)
                        && (i_activation_f32[22:0] != 23'd0);
        o_item.bias   = i_bias_f32;
        o_item.first  = i_first_of_row;
        o_item.last   = i_last_of_row;
    end

endmodule

### src/bwdp_queue.sv
// Short queue of classified transactions between front and back end.
module bwdp_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  bwdp_pkg::t_item      i_item,
    input  logic                 i_pop,
    output bwdp_pkg::t_item      o_item,
    output bwdp_pkg::t_qstat     o_stat
);
    import bwdp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push;
    logic          do_pop;

    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_item       = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

### src/bwdp_mul.sv
// Two-stage binary32 multiplier: significand product, then normalise and round.
module bwdp_mul (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  logic                 i_valid,
    input  bwdp_pkg::t_item      i_item,
    output logic                 o_valid,
    output bwdp_pkg::t_pstage    o_stage
);
    import bwdp_pkg::*;

    t_mstage r_m, n_m;
    logic    r_m_valid;
    t_pstage r_p, n_p;
    logic    r_p_valid;

    // Stage 1: classify and multiply significands.
    always_comb begin
        n_m.sign  = i_item.w_sign ^ i_item.a_sign;
        n_m.nan   = i_item.w_nan || i_item.a_nan
                    || (i_item.w_inf && i_item.a_zero)
                    || (i_item.a_inf && i_item.w_zero);
        n_m.inf   = i_item.w_inf || i_item.a_inf;
        n_m.zero  = i_item.w_zero || i_item.a_zero;
        n_m.prod  = 32'(i_item.w_sig) * 32'(i_item.a_sig);
        n_m.esum  = $signed({3'b000, i_item.w_exp}) + $signed({3'b000, i_item.a_exp})
                    - 11'sd127;
        n_m.bias  = i_item.bias;
        n_m.first = i_item.first;
        n_m.last  = i_item.last;
    end

    // Stage 2: normalise, denormalise where tiny, round to nearest even.
    logic [5:0]         lz;
    logic [31:0]        pn;
    logic signed [10:0] e;
    logic signed [10:0] rsn;
    logic [5:0]         rsc;
    logic [63:0]        q;
    logic [7:0]         expf;
    logic [22:0]        frac;
    logic               inc;
    logic [30:0]        rnd;

    always_comb begin
        lz   = lzc32(r_m.prod);
        pn   = r_m.prod << lz[4:0];
        e    = r_m.esum + 11'sd1 - $signed({5'b00000, lz});
        rsn  = 11'sd1 - e;
        if (e >= 11'sd1) begin
            rsc = 6'd0;
        end else if (rsn > 11'sd63) begin
            rsc = 6'd63;
        end else begin
            rsc = rsn[5:0];
        end
        q    = {pn, 32'd0} >> rsc;
        frac = q[62:40];
        inc  = q[39] && ((|q[38:0]) || frac[0]);
        expf = (e >= 11'sd1) ? e[7:0] : 8'd0;
        rnd  = {expf, frac} + 31'(inc);

        n_p.bias  = r_m.bias;
        n_p.first = r_m.first;
        n_p.last  = r_m.last;
        if (r_m.nan) begin
            n_p.prod_bits = CANON_NAN;
        end else if (r_m.inf || (e >= 11'sd255)) begin
            n_p.prod_bits = {r_m.sign, EXP_MAX, 23'd0};
        end else if (r_m.zero) begin
            n_p.prod_bits = {r_m.sign, 31'd0};
        end else begin
            n_p.prod_bits = {r_m.sign, rnd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_p_valid <= 1'b0;
        end else if (i_advance) begin
            r_m_valid <= i_valid;
            r_p_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_m <= n_m;
            r_p <= n_p;
        end
    end

    assign o_valid = r_p_valid;
    assign o_stage = r_p;

endmodule

### src/bwdp_acc.sv
// Accumulator: combinational binary32 add into the row sum, plus output register.
module bwdp_acc (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  bwdp_pkg::t_pstage    i_stage,
    input  logic                 i_out_ready,
    output logic                 o_advance,
    output logic                 o_out_valid,
    output logic [31:0]          o_row_sum
);
    import bwdp_pkg::*;

    logic [31:0] r_acc;
    logic [31:0] r_out;
    logic        r_out_valid;

    logic [31:0] x, y, big, sml, sum;
    logic        x_nan, y_nan, x_inf, y_inf, swap, sub;
    logic [7:0]  be, se, d;
    logic [4:0]  dcap;
    logic [26:0] mb, ms, ms_al, m;
    logic [54:0] shv;
    logic [27:0] z;
    logic [5:0]  lz, nsh;
    logic [8:0]  ex, expf;
    logic        inc, zsign;
    logic [30:0] rnd;

    assign o_advance = !r_out_valid || i_out_ready;

    always_comb begin
        x     = i_stage.first ? i_stage.bias : r_acc;
        y     = i_stage.prod_bits;
        x_nan = (x[30:23] == EXP_MAX) && (x[22:0] != 23'd0);
        y_nan = (y[30:23] == EXP_MAX) && (y[22:0] != 23'd0);
        x_inf = (x[30:23] == EXP_MAX) && (x[22:0] == 23'd0);
        y_inf = (y[30:23] == EXP_MAX) && (y[22:0] == 23'd0);

        // Larger magnitude first.
        swap  = (y[30:0] > x[30:0]);
        big   = swap ? y : x;
        sml   = swap ? x : y;
        sub   = big[31] ^ sml[31];
        be    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        se    = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        d     = be - se;
        dcap  = (d > 8'd27) ? 5'd28 : d[4:0];
        mb    = {big[30:23] != 8'd0, big[22:0], 3'b000};
        ms    = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
        shv   = {ms, 28'd0} >> dcap;
        ms_al = shv[54:28] | {26'd0, |shv[27:0]};
        z     = sub ? ({1'b0, mb} - {1'b0, ms_al}) : ({1'b0, mb} + {1'b0, ms_al});

        lz    = lzc32({z[26:0], 5'h1F});
        if (z[27]) begin
            nsh = 6'd0;
            m   = {z[27:2], z[1] | z[0]};
            ex  = {1'b0, be} + 9'd1;
        end else begin
            nsh = (9'(lz) < ({1'b0, be} - 9'd1)) ? lz : 6'(be - 8'd1);
            m   = z[26:0] << nsh;
            ex  = {1'b0, be} - 9'(nsh);
        end
        expf  = m[26] ? ex : 9'd0;
        inc   = m[2] && ((|m[1:0]) || m[3]);
        rnd   = {expf[7:0], m[25:3]} + 31'(inc);
        zsign = (z == 28'd0) ? (sub ? 1'b0 : big[31]) : big[31];

        if (x_nan || y_nan || (x_inf && y_inf && (x[31] != y[31]))) begin
            sum = CANON_NAN;
        end else if (x_inf) begin
            sum = x;
        end else if (y_inf) begin
            sum = y;
        end else if (expf >= 9'd255) begin
            sum = {zsign, EXP_MAX, 23'd0};
        end else begin
            sum = {zsign, rnd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= 32'd0;
            r_out_valid <= 1'b0;
        end else if (o_advance) begin
            r_out_valid <= i_valid && i_stage.last;
            if (i_valid) begin
                r_acc <= sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_valid && i_stage.last) begin
            r_out <= sum;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_row_sum   = r_out;

endmodule

### src/bf16_weight_dot_product.sv
// A last_of_row transaction and its sum pass queue, product, rounding and output registers.
// One transaction per cycle unless a row sum waits unclaimed; accumulation is combinational.
// The queue lets the input take up to QUEUE_DEPTH transactions while the result is held.
// Reset (synchronous, active low) empties queue and pipe and clears the sum to +0.0.
// Top level of the bf16 weight by fp32 activation dot product block.
`include "bf16_weight_dot_product_defines.svh"
module bf16_weight_dot_product #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_weight_bf16,
    input  logic [31:0] i_activation_f32,
    input  logic [31:0] i_bias_f32,
    input  logic        i_first_of_row,
    input  logic        i_last_of_row,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_row_sum_f32
);
    import bwdp_pkg::*;

    t_item   front_item;
    t_item   q_item;
    t_qstat  q_stat;
    t_pstage p_stage;
    logic    p_valid;
    logic    advance;

    // Front end classifies the operands; the transaction goes straight into the queue.
    bwdp_front u_front (
        .i_weight_bf16    (i_weight_bf16),
        .i_activation_f32 (i_activation_f32),
        .i_bias_f32       (i_bias_f32),
        .i_first_of_row   (i_first_of_row),
        .i_last_of_row    (i_last_of_row),
        .o_item           (front_item)
    );

    assign o_in_ready = !q_stat.full;

    bwdp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_item  (front_item),
        .i_pop   (advance),
        .o_item  (q_item),
        .o_stat  (q_stat)
    );

    // Back end: whole pipe moves together, held only while a result waits unclaimed.
    bwdp_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_valid   (!q_stat.empty),
        .i_item    (q_item),
        .o_valid   (p_valid),
        .o_stage   (p_stage)
    );

    bwdp_acc u_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (p_valid),
        .i_stage     (p_stage),
        .i_out_ready (i_out_ready),
        .o_advance   (advance),
        .o_out_valid (o_out_valid),
        .o_row_sum   (o_row_sum_f32)
    );

    // Queue cannot report full and empty at once.
    `ASSERT_IMPL(a_queue_state, i_clk, i_rst_n, q_stat.full, !q_stat.empty, "queue full and empty")
    // A held result freezes the back end.
    `ASSERT_IMPL(a_stall, i_clk, i_rst_n, o_out_valid && !i_out_ready, !advance, "pipe moved under stall")
    // Any NaN row sum leaves in canonical form.
    `ASSERT_IMPL(a_canon_nan, i_clk, i_rst_n, o_out_valid && (o_row_sum_f32[30:23] == 8'hFF) && (o_row_sum_f32[22:0] != 23'd0), o_row_sum_f32 == CANON_NAN, "non-canonical NaN")

endmodule

### test/tb_bf16_weight_dot_product.sv
// Testbench for the bf16 weight by fp32 activation dot product block.
`timescale 1ns / 1ps

module tb_bf16_weight_dot_product;
    import bwdp_pkg::*;

    // Binary32 field constants for the soft-float row-sum model
    localparam logic [7:0]  F32_EXP_ALL1 = 8'hFF;
    localparam int          F32_BIAS_Q   = 150;   // bias plus fraction width
    localparam int          F32_QMIN     = -149;  // quantum of the subnormals
    localparam int          WATCHDOG_MAX = 2000;
    localparam int          MAX_GAP      = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [15:0] i_weight_bf16 = '0;
    logic [31:0] i_activation_f32 = '0;
    logic [31:0] i_bias_f32 = '0;
    logic        i_first_of_row = 1'b0;
    logic        i_last_of_row = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_row_sum_f32;

    bf16_weight_dot_product dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_weight_bf16    (i_weight_bf16),
        .i_activation_f32 (i_activation_f32),
        .i_bias_f32       (i_bias_f32),
        .i_first_of_row   (i_first_of_row),
        .i_last_of_row    (i_last_of_row),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_row_sum_f32    (o_row_sum_f32)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Model state: running binary32 sum, plus the row sums still owed by the block
    logic [31:0] acc_model = '0;
    logic [31:0] row_sums_due[$];
    int          n_errors = 0;
    int          n_sent = 0;
    int          n_rows = 0;
    int          idle_cycles = 0;
    bit          in_no_gaps = 1'b0;   // stretches where the sender never idles
    bit          out_no_stall = 1'b0; // stretches where the receiver never stalls

    // ---------------------------------------------------------------------
    // Soft-float binary32 arithmetic, round to nearest even, subnormals kept
    // ---------------------------------------------------------------------
    function automatic bit is_nan(logic [31:0] x);
        return x[30:23] == F32_EXP_ALL1 && x[22:0] != '0;
    endfunction

    function automatic bit is_inf(logic [31:0] x);
        return x[30:23] == F32_EXP_ALL1 && x[22:0] == '0;
    endfunction

    function automatic bit is_zero(logic [31:0] x);
        return x[30:0] == '0;
    endfunction

    // Significand with hidden bit, and the weight of its lsb as a power of two
    function automatic logic [23:0] sig_of(logic [31:0] x);
        return (x[30:23] == '0) ? {1'b0, x[22:0]} : {1'b1, x[22:0]};
    endfunction

    function automatic int lsb_exp(logic [31:0] x);
        return ((x[30:23] == '0) ? 1 : int'(x[30:23])) - F32_BIAS_Q;
    endfunction

    // Round the exact value m * 2^e2 (m nonzero) to binary32
    function automatic logic [31:0] round_pack(logic s, int e2, logic [127:0] m);
        int           msb;
        int           q;
        int           sh;
        logic [127:0] kept;
        logic [127:0] rem;
        logic [127:0] half;
        msb = 0;
        for (int i = 0; i < 128; i++) begin
            if (m[i]) msb = i;
        end
        q = msb + e2 - 23;
        if (q < F32_QMIN) q = F32_QMIN;
        sh = q - e2;
        if (sh <= 0) begin
            kept = m << (-sh);
        end else if (sh > 120) begin
            kept = '0;  // far below half a quantum
        end else begin
            kept = m >> sh;
            rem  = m & ((128'd1 << sh) - 128'd1);
            half = 128'd1 << (sh - 1);
            if (rem > half || (rem == half && kept[0])) kept = kept + 128'd1;
        end
        if (kept == (128'd1 << 24)) begin
            kept = kept >> 1;
            q++;
        end
        if (kept < (128'd1 << 23)) return {s, 8'd0, kept[22:0]};
        if (q + F32_BIAS_Q >= 255) return {s, F32_EXP_ALL1, 23'd0};
        return {s, 8'(q + F32_BIAS_Q), kept[22:0]};
    endfunction

    function automatic logic [31:0] f32_mul(logic [31:0] a, logic [31:0] b);
        logic s;
        s = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b)) return CANON_NAN;
        if (is_inf(a) || is_inf(b)) begin
            if (is_zero(a) || is_zero(b)) return CANON_NAN;
            return {s, F32_EXP_ALL1, 23'd0};
        end
        if (is_zero(a) || is_zero(b)) return {s, 31'd0};
        return round_pack(s, lsb_exp(a) + lsb_exp(b),
                          128'(sig_of(a)) * 128'(sig_of(b)));
    endfunction

    function automatic logic [31:0] f32_add(logic [31:0] a, logic [31:0] b);
        logic [31:0]         hi;
        logic [31:0]         lo;
        logic signed [127:0] mh;
        logic signed [127:0] ml;
        logic signed [127:0] r;
        int                  d;
        int                  e2;
        if (is_nan(a) || is_nan(b)) return CANON_NAN;
        if (is_inf(a) && is_inf(b)) return (a[31] != b[31]) ? CANON_NAN : a;
        if (is_inf(a)) return a;
        if (is_inf(b)) return b;
        if (is_zero(a) && is_zero(b)) return {a[31] & b[31], 31'd0};
        if (is_zero(a)) return b;
        if (is_zero(b)) return a;
        if (lsb_exp(a) >= lsb_exp(b)) begin
            hi = a; lo = b;
        end else begin
            hi = b; lo = a;
        end
        d = lsb_exp(hi) - lsb_exp(lo);
        if (d > 60) begin
            // small operand only matters as a sticky bit far below the round point
            mh = 128'(sig_of(hi)) << 60;
            ml = 128'sd1;
            e2 = lsb_exp(hi) - 60;
        end else begin
            mh = 128'(sig_of(hi)) << d;
            ml = 128'(sig_of(lo));
            e2 = lsb_exp(lo);
        end
        if (hi[31]) mh = -mh;
        if (lo[31]) ml = -ml;
        r = mh + ml;
        if (r == 0) return 32'd0;  // exact cancel gives +0 under nearest-even
        if (r < 0) return round_pack(1'b1, e2, 128'(-r));
        return round_pack(1'b0, e2, 128'(r));
    endfunction

    // One accepted element: update the running sum, owe a row sum on the last one
    task automatic accumulate_element(logic [15:0] w, logic [31:0] a, logic [31:0] b,
                                      logic first, logic last);
        logic [31:0] prod;
        logic [31:0] sum;
        if (first) acc_model = b;
        prod = f32_mul({w, 16'd0}, a);
        sum  = f32_add(acc_model, prod);
        acc_model = is_nan(sum) ? CANON_NAN : sum;
        if (last) begin
            row_sums_due.push_back(acc_model);
            n_rows++;
        end
    endtask

    // ---------------------------------------------------------------------
    // Input side: one transaction per call, random idle before it
    // ---------------------------------------------------------------------
    task automatic send_element(logic [15:0] w, logic [31:0] a, logic [31:0] b,
                                logic first, logic last);
        int gap;
        gap = in_no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_weight_bf16    <= w;
        i_activation_f32 <= a;
        i_bias_f32       <= b;
        i_first_of_row   <= first;
        i_last_of_row    <= last;
        do @(posedge i_clk); while (!o_in_ready);
        accumulate_element(w, a, b, first, last);
        n_sent++;
    endtask

    // Random binary32 with heavy weight on special classes
    function automatic logic [31:0] rand_f32();
        logic [31:0] x;
        x = $urandom;
        case ($urandom_range(0, 15))
            0: x = {x[31], 31'd0};
            1: x = {x[31], F32_EXP_ALL1, 23'd0};
            2: x = {x[31], F32_EXP_ALL1, x[22] | 1'b1, x[21:0]};
            3: x = {x[31], 8'd0, x[22:0]};
            4: ;
            5: x = {x[31], 8'($urandom_range(1, 254)), x[22:0]};
            default: x = {x[31], 8'($urandom_range(107, 147)), x[22:0]};
        endcase
        return x;
    endfunction

    // bf16 is the top half of a binary32; keep NaN payloads inside those bits
    function automatic logic [15:0] rand_bf16();
        logic [31:0] x;
        x = rand_f32();
        if (x[30:23] == F32_EXP_ALL1 && x[22:16] == '0 && x[15:0] != '0) x[16] = 1'b1;
        return x[31:16];
    endfunction

    // Receiver: each result waits a drawn number of stall cycles
    int out_stall = 0;
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            out_stall   = out_no_stall ? 0 : $urandom_range(0, MAX_GAP);
            i_out_ready <= (out_stall == 0);
        end else if (out_stall > 0) begin
            out_stall--;
            i_out_ready <= (out_stall == 0);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Result checker against the oldest owed row sum
    always @(posedge i_clk) begin
        logic [31:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (row_sums_due.size() == 0) begin
                $display("%0t: unexpected row sum, expected none, actual %h",
                         $time, o_row_sum_f32);
                n_errors++;
            end else begin
                want = row_sums_due.pop_front();
                if (o_row_sum_f32 !== want) begin
                    $display("%0t: row_sum_f32 mismatch, expected %h, actual %h",
                             $time, want, o_row_sum_f32);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_MAX);
            $display("status: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------
    task automatic test_extremes();
        // continuing without a start right after reset adds to +0.0
        send_element(16'h3F80, 32'h4040_0000, 32'h1234_5678, 1'b0, 1'b1);
        // field extremes, all ones and all zeros
        send_element(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_element(16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1);
        send_element(16'h7F7F, 32'h7F7F_FFFF, 32'h0000_0000, 1'b1, 1'b1); // overflow
        send_element(16'h0001, 32'h0000_0001, 32'h8000_0000, 1'b1, 1'b1); // underflow
        send_element(16'h0080, 32'h3F00_0000, 32'h0000_0001, 1'b1, 1'b1); // subnormal
    endtask

    task automatic test_nan_inf();
        send_element(16'h7F80, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1); // inf * 0
        send_element(16'h7F80, 32'h3F80_0000, 32'hFF80_0000, 1'b1, 1'b1); // inf - inf
        send_element(16'h7FC1, 32'h3F80_0000, 32'h0000_0000, 1'b1, 1'b0); // NaN weight
        send_element(16'h3F80, 32'h3F80_0000, 32'h0000_0000, 1'b0, 1'b1); // NaN carried
        send_element(16'h3F80, 32'hFFBF_FFFF, 32'h7F80_0001, 1'b1, 1'b1); // NaN bias
        send_element(16'hFF80, 32'hBF80_0000, 32'h0000_0000, 1'b1, 1'b1); // +inf
    endtask

    task automatic test_row_forms();
        // ordinary row with bias, then a row continuing from the emitted sum
        send_element(16'h4000, 32'h3FC0_0000, 32'h3F80_0000, 1'b1, 1'b0);
        send_element(16'hC000, 32'h4000_0000, 32'hDEAD_BEEF, 1'b0, 1'b0); // bias unused
        send_element(16'h3F00, 32'h4080_0000, 32'h0000_0000, 1'b0, 1'b1);
        send_element(16'h3F80, 32'h3F80_0000, 32'h0000_0000, 1'b0, 1'b1);
        // exact cancellation and a tie under round to nearest even
        send_element(16'h3F80, 32'h3F80_0000, 32'hBF80_0000, 1'b1, 1'b1);
        send_element(16'h3380, 32'h3F80_0000, 32'h3F80_0000, 1'b1, 1'b1);
        send_element(16'h3F80, 32'h3380_0001, 32'h3F80_0000, 1'b1, 1'b1);
    endtask

    // Well-formed rows with random content, plus some noise transactions
    task automatic test_random_rows(int n_items);
        int  len;
        int  done;
        logic first;
        logic last;
        done = 0;
        while (done < n_items) begin
            if ($urandom_range(0, 49) == 0) in_no_gaps = ~in_no_gaps;
            if ($urandom_range(0, 49) == 0) out_no_stall = ~out_no_stall;
            if ($urandom_range(0, 7) == 0) begin
                first = 1'($urandom_range(0, 1));
                last  = 1'($urandom_range(0, 1));
                send_element(rand_bf16(), rand_f32(), $urandom, first, last);
                done++;
            end else begin
                len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(9, 24))
                                                  : int'($urandom_range(1, 8));
                for (int k = 0; k < len; k++) begin
                    send_element(rand_bf16(), rand_f32(),
                                 ($urandom_range(0, 2) == 0) ? 32'd0 : rand_f32(),
                                 k == 0, k == len - 1);
                end
                done += len;
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_nan_inf();
        test_row_forms();
        test_random_rows(630);
        i_in_valid <= 1'b0;
        wait (row_sums_due.size() == 0);
        repeat (20) @(posedge i_clk);
        $display("covered %0d element transactions and %0d row sums,", n_sent, n_rows);
        $display("including specials, subnormals, overflow and idle/stall gaps");
        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### files.f
+incdir+src
src/bwdp_pkg.sv
src/bwdp_front.sv
src/bwdp_queue.sv
src/bwdp_mul.sv
src/bwdp_acc.sv
src/bf16_weight_dot_product.sv
test/tb_bf16_weight_dot_product.sv
